### hdl/gamepad_direction_repeat_filter_assert.svh
// Assertion macros for the gamepad direction repeat filter.
// Depends on signals clk and rst_n in the including module.
`ifndef GAMEPAD_DIRECTION_REPEAT_FILTER_ASSERT_SVH
`define GAMEPAD_DIRECTION_REPEAT_FILTER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define GDRF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, held off during reset.
`define GDRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

### hdl/gdrf_pkg.sv
// Package for the gamepad direction repeat filter: payload types, key codes,
// register indexes, rumble levels and stick helper functions. No dependencies.
package gdrf_pkg;

  // Key codes of the result channel
  typedef enum logic [3:0] {
    KEY_IDLE         = 4'd0,
    KEY_MOVE_UP      = 4'd1,
    KEY_MOVE_DOWN    = 4'd2,
    KEY_MOVE_LEFT    = 4'd3,
    KEY_MOVE_RIGHT   = 4'd4,
    KEY_ACTION_UP    = 4'd5,
    KEY_ACTION_DOWN  = 4'd6,
    KEY_ACTION_LEFT  = 4'd7,
    KEY_ACTION_RIGHT = 4'd8,
    KEY_PREV         = 4'd9,
    KEY_NEXT         = 4'd10,
    KEY_MENU_PAUSE   = 4'd11
  } key_code_t;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEFT_DEAD_ZONE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RIGHT_DEAD_ZONE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_DELAY    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RUMBLE_HOLD     = 2'd3;

  // Register reset values
  localparam logic [14:0] LEFT_DEAD_ZONE_RST  = 15'd7849;
  localparam logic [14:0] RIGHT_DEAD_ZONE_RST = 15'd8689;
  localparam logic [7:0]  REPEAT_DELAY_RST    = 8'd10;
  localparam logic [7:0]  RUMBLE_HOLD_RST     = 8'd17;

  // Motor levels: intensity times the level unit
  localparam int unsigned LEVEL_UNIT       = 655;
  localparam int unsigned ACTION_INTENSITY = 15;
  localparam int unsigned PAUSE_INTENSITY  = 50;
  localparam logic [15:0] ACTION_LEVEL = 16'(ACTION_INTENSITY * LEVEL_UNIT);
  localparam logic [15:0] PAUSE_LEVEL  = 16'(PAUSE_INTENSITY * LEVEL_UNIT);

  typedef struct packed {
    logic               connected;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic               left_shoulder;
    logic               right_shoulder;
    logic               start_button;
    logic               a_button;
  } in_item_t;

  typedef struct packed {
    key_code_t   key_code;
    logic        rumble_start;
    logic [15:0] motor_level;
    logic        rumble_stop;
  } out_item_t;

  // True when an axis lies strictly inside +/- dz
  function automatic logic in_dead_zone(logic signed [15:0] v, logic [14:0] dz);
    logic signed [16:0] sv;
    logic signed [16:0] dzp;
    logic signed [16:0] dzn;
    sv  = {v[15], v};
    dzp = {2'b00, dz};
    dzn = -dzp;
    return (sv < dzp) && (sv > dzn);
  endfunction

  // Axis magnitude; 17 bits so that -32768 fits
  function automatic logic [16:0] axis_mag(logic signed [15:0] v);
    logic signed [16:0] sv;
    sv = {v[15], v};
    return sv[16] ? 17'(-sv) : 17'(sv);
  endfunction

endpackage

### hdl/gamepad_direction_repeat_filter.sv
// Gamepad direction repeat filter, top level.
// Uses gdrf_pkg and gamepad_direction_repeat_filter_assert.svh.
//
// Usage:
//   Input channel in_valid/in_stall/in_item carries one controller poll per
//   transfer; the result channel out_valid/out_stall/out_item returns exactly
//   one result (key code, rumble start with motor level, rumble stop) per poll,
//   in order. A transfer happens when valid is high and stall is low.
//   The configuration port writes register cfg_addr with cfg_wdata when cfg_we
//   is high: 0 left dead zone, 1 right dead zone, 2 repeat delay, 3 rumble hold.
//   Write registers only while no poll is in flight.
//   Path: a poll taken into the input register goes through the key/filter
//   logic into the result register, from which it transfers.
//   Throughput: one poll per cycle while the receiver does not stall; the
//   filter and rumble counters update as a poll moves into the result register.
//   Reset (rst_n low at a clock edge) empties both stages, clears the last key
//   and both counters, and loads the register defaults.
//   When the receiver stalls, the result register holds; the input register
//   keeps taking one more poll, then in_stall rises until the result moves.
module gamepad_direction_repeat_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  gdrf_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output gdrf_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [gdrf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [gdrf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import gdrf_pkg::*;

  `include "gamepad_direction_repeat_filter_assert.svh"

  // Configuration registers
  logic [14:0] left_dead_zone_r;
  logic [14:0] right_dead_zone_r;
  logic [7:0]  repeat_delay_r;
  logic [7:0]  rumble_hold_r;

  // Filter state
  key_code_t   last_key_r, last_key_nxt;
  logic [7:0]  repeat_count_r, repeat_count_nxt;
  logic [7:0]  rumble_count_r, rumble_count_nxt;

  // Pipeline registers
  logic        s1_valid_r;
  in_item_t    s1_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r, out_item_nxt;

  logic        advance;
  logic        in_take;
  logic        passed;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_dead_zone_r  <= LEFT_DEAD_ZONE_RST;
      right_dead_zone_r <= RIGHT_DEAD_ZONE_RST;
      repeat_delay_r    <= REPEAT_DELAY_RST;
      rumble_hold_r     <= RUMBLE_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LEFT_DEAD_ZONE:  left_dead_zone_r  <= cfg_wdata;
        CFG_RIGHT_DEAD_ZONE: right_dead_zone_r <= cfg_wdata;
        CFG_REPEAT_DELAY:    repeat_delay_r    <= cfg_wdata[7:0];
        CFG_RUMBLE_HOLD:     rumble_hold_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Decode the poll, run the repeat filter and the rumble hold counter
  always_comb begin
    logic        left_zero;
    logic        right_zero;
    logic        left_act;
    logic        right_act;
    key_code_t   key;
    logic        start;
    logic [15:0] level;
    logic        stop;
    logic [7:0]  rumble_base;

    left_zero  = in_dead_zone(s1_item_r.left_x, left_dead_zone_r) &&
                 in_dead_zone(s1_item_r.left_y, left_dead_zone_r);
    right_zero = in_dead_zone(s1_item_r.right_x, right_dead_zone_r) &&
                 in_dead_zone(s1_item_r.right_y, right_dead_zone_r);
    left_act   = !left_zero && (s1_item_r.left_x != 16'sd0 || s1_item_r.left_y != 16'sd0);
    right_act  = !right_zero &&
                 (s1_item_r.right_x != 16'sd0 || s1_item_r.right_y != 16'sd0);

    key   = KEY_IDLE;
    start = 1'b0;
    level = 16'd0;
    stop  = 1'b0;

    // Pick the raw key by priority
    if (s1_item_r.connected) begin
      priority if (left_act) begin
        if (axis_mag(s1_item_r.left_x) > axis_mag(s1_item_r.left_y)) begin
          key = s1_item_r.left_x[15] ? KEY_MOVE_LEFT : KEY_MOVE_RIGHT;
        end else begin
          key = s1_item_r.left_y[15] ? KEY_MOVE_DOWN : KEY_MOVE_UP;
        end
      end else if (right_act) begin
        start = 1'b1;
        level = ACTION_LEVEL;
        if (axis_mag(s1_item_r.right_x) > axis_mag(s1_item_r.right_y)) begin
          key = s1_item_r.right_x[15] ? KEY_ACTION_LEFT : KEY_ACTION_RIGHT;
        end else begin
          key = (s1_item_r.right_y > 16'sd0) ? KEY_ACTION_DOWN : KEY_ACTION_UP;
        end
      end else if (s1_item_r.left_shoulder) begin
        key = KEY_PREV;
      end else if (s1_item_r.right_shoulder) begin
        key = KEY_NEXT;
      end else if (s1_item_r.start_button || s1_item_r.a_button) begin
        start = 1'b1;
        level = PAUSE_LEVEL;
        key   = KEY_MENU_PAUSE;
      end else begin
        key = KEY_IDLE;
      end
    end

    // Repeat filter: pass a new key, or any key once the delay has run out
    last_key_nxt     = last_key_r;
    repeat_count_nxt = repeat_count_r;
    passed           = 1'b0;
    if (repeat_count_r == 8'd0 || key != last_key_r) begin
      if (key != KEY_IDLE) begin
        last_key_nxt     = key;
        repeat_count_nxt = repeat_delay_r;
        passed           = 1'b1;
      end
    end else begin
      repeat_count_nxt = repeat_count_r - 8'd1;
    end

    // Rumble hold: load on start, count down only on polls that pass no key
    rumble_base      = start ? rumble_hold_r : rumble_count_r;
    rumble_count_nxt = rumble_base;
    if (!passed) begin
      if (rumble_base == 8'd1) begin
        rumble_count_nxt = 8'd0;
        stop             = 1'b1;
      end else if (rumble_base > 8'd1) begin
        rumble_count_nxt = rumble_base - 8'd1;
      end
    end

    out_item_nxt.key_code     = passed ? key : KEY_IDLE;
    out_item_nxt.rumble_start = start;
    out_item_nxt.motor_level  = level;
    out_item_nxt.rumble_stop  = stop;
  end

  // Advance the control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      last_key_r     <= KEY_IDLE;
      repeat_count_r <= 8'd0;
      rumble_count_r <= 8'd0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r    <= 1'b1;
        last_key_r     <= last_key_nxt;
        repeat_count_r <= repeat_count_nxt;
        rumble_count_r <= rumble_count_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold payloads unless a transfer moves them
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  // Checks on the filter and pipeline
  `GDRF_ASSERT_NOW(a_stall_needs_item, !s1_valid_r, !in_stall)
  `GDRF_ASSERT_NOW(a_key_is_last, out_valid_r && out_item_r.key_code != KEY_IDLE,
                   last_key_r == out_item_r.key_code)
  `GDRF_ASSERT_NEXT(a_pass_loads_delay, advance && passed,
                    repeat_count_r == $past(repeat_delay_r))
  `GDRF_ASSERT_NEXT(a_stop_clears_hold, advance && out_item_nxt.rumble_stop,
                    rumble_count_r == 8'd0 && out_valid_r && out_item_r.rumble_stop)

endmodule

### verif/gamepad_direction_repeat_filter_tb.sv
// Self-checking testbench for the gamepad direction repeat filter.
// Depends on gdrf_pkg and the gamepad_direction_repeat_filter top level.
// Drives polls with random idling and receiver stalls, predicts every result.
`timescale 1ns / 100ps

module gamepad_direction_repeat_filter_tb;
  import gdrf_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;

  // Key and rumble predictor with its own copy of the registers and state
  class poll_scoreboard;
    logic [14:0] left_dz;
    logic [14:0] right_dz;
    logic [7:0]  delay;
    logic [7:0]  hold;
    key_code_t   last_key;
    logic [7:0]  repeat_cnt;
    logic [7:0]  rumble_cnt;
    out_item_t   expected_q[$];
    int unsigned mismatches;

    function new();
      left_dz    = LEFT_DEAD_ZONE_RST;
      right_dz   = RIGHT_DEAD_ZONE_RST;
      delay      = REPEAT_DELAY_RST;
      hold       = RUMBLE_HOLD_RST;
      last_key   = KEY_IDLE;
      repeat_cnt = '0;
      rumble_cnt = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_LEFT_DEAD_ZONE:  left_dz  = val[14:0];
        CFG_RIGHT_DEAD_ZONE: right_dz = val[14:0];
        CFG_REPEAT_DELAY:    delay    = val[7:0];
        CFG_RUMBLE_HOLD:     hold     = val[7:0];
        default: ;
      endcase
    endfunction

    function bit dead_zone_hit(int v, int dz);
      return (v < dz) && (v > -dz);
    endfunction

    function int magnitude(int v);
      return (v < 0) ? -v : v;
    endfunction

    // Work out the result of one accepted poll and queue it
    function void note_poll(in_item_t p);
      int        lx;
      int        ly;
      int        rx;
      int        ry;
      key_code_t key;
      logic      start;
      logic      stop;
      logic [15:0] level;
      bit        passed;
      out_item_t e;
      lx = int'(p.left_x);
      ly = int'(p.left_y);
      rx = int'(p.right_x);
      ry = int'(p.right_y);
      key = KEY_IDLE;
      start = 1'b0;
      stop = 1'b0;
      level = '0;
      if (p.connected) begin
        if (dead_zone_hit(lx, int'(left_dz)) && dead_zone_hit(ly, int'(left_dz))) begin
          lx = 0;
          ly = 0;
        end
        if (dead_zone_hit(rx, int'(right_dz)) && dead_zone_hit(ry, int'(right_dz))) begin
          rx = 0;
          ry = 0;
        end
        if (lx != 0 || ly != 0) begin
          if (magnitude(lx) > magnitude(ly)) key = (lx < 0) ? KEY_MOVE_LEFT : KEY_MOVE_RIGHT;
          else key = (ly < 0) ? KEY_MOVE_DOWN : KEY_MOVE_UP;
        end else if (rx != 0 || ry != 0) begin
          start = 1'b1;
          level = ACTION_LEVEL;
          if (magnitude(rx) > magnitude(ry)) key = (rx < 0) ? KEY_ACTION_LEFT : KEY_ACTION_RIGHT;
          else key = (ry > 0) ? KEY_ACTION_DOWN : KEY_ACTION_UP;
        end else if (p.left_shoulder) begin
          key = KEY_PREV;
        end else if (p.right_shoulder) begin
          key = KEY_NEXT;
        end else if (p.start_button || p.a_button) begin
          start = 1'b1;
          level = PAUSE_LEVEL;
          key = KEY_MENU_PAUSE;
        end
        if (start) rumble_cnt = hold;
      end
      // Repeat filter: pass a new key, or any key once the delay ran out
      passed = 1'b0;
      if (repeat_cnt == 0 || key != last_key) begin
        if (key != KEY_IDLE) begin
          last_key = key;
          repeat_cnt = delay;
          passed = 1'b1;
        end
      end else begin
        repeat_cnt = repeat_cnt - 8'd1;
      end
      // Rumble hold only advances on polls that pass no key
      if (!passed) begin
        key = KEY_IDLE;
        if (rumble_cnt == 8'd1) begin
          rumble_cnt = '0;
          stop = 1'b1;
        end else if (rumble_cnt > 8'd1) begin
          rumble_cnt = rumble_cnt - 8'd1;
        end
      end
      e.key_code = key;
      e.rumble_start = start;
      e.motor_level = level;
      e.rumble_stop = stop;
      expected_q.push_back(e);
    endfunction

    function void report(string what, out_item_t e, out_item_t g);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch (%s) at %0t: expected key %0d start %0b level %0d stop %0b,",
                 what, $realtime, e.key_code, e.rumble_start, e.motor_level, e.rumble_stop,
                 " got key %0d start %0b level %0d stop %0b",
                 g.key_code, g.rumble_start, g.motor_level, g.rumble_stop);
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(out_item_t g);
      out_item_t e;
      if (expected_q.size() == 0) begin
        report("no result expected", '0, g);
        return;
      end
      e = expected_q.pop_front();
      if (g.key_code !== e.key_code || g.rumble_start !== e.rumble_start ||
          g.motor_level !== e.motor_level || g.rumble_stop !== e.rumble_stop)
        report("field", e, g);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_LEFT_DEAD_ZONE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  poll_scoreboard board = new();
  int unsigned    idle_pct = 15;
  int unsigned    quiet_cycles = 0;

  gamepad_direction_repeat_filter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_item);
  end

  // Receiver stalls in random bursts
  always begin
    @(posedge clk);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 18)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic in_item_t mk(int conn, int lx, int ly, int rx, int ry,
                                  int lsh, int rsh, int st, int a);
    in_item_t p;
    p.connected = 1'(conn);
    p.left_x = 16'(lx);
    p.left_y = 16'(ly);
    p.right_x = 16'(rx);
    p.right_y = 16'(ry);
    p.left_shoulder = 1'(lsh);
    p.right_shoulder = 1'(rsh);
    p.start_button = 1'(st);
    p.a_button = 1'(a);
    return p;
  endfunction

  // Axis value biased toward the dead zone edges and the extremes
  function automatic logic signed [15:0] rand_axis(int dz);
    int v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = dz;
      2: v = dz - 1;
      3: v = dz + 1;
      4: v = 32767;
      5: v = -32768;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v != -32768 && v != 32767 && $urandom_range(0, 1)) v = -v;
    return 16'(v);
  endfunction

  // Axis value strictly inside the dead zone, or zero when the zone is empty
  function automatic logic signed [15:0] rand_inside(int dz);
    int v;
    if (dz <= 1) return '0;
    v = $urandom_range(0, dz - 1);
    if ($urandom_range(0, 1)) v = -v;
    return 16'(v);
  endfunction

  // One poll of a random kind; every field starts fully random
  function automatic in_item_t rand_poll(int ldz, int rdz);
    in_item_t p;
    p.connected = 1'($urandom_range(0, 1));
    p.left_x = 16'($urandom);
    p.left_y = 16'($urandom);
    p.right_x = 16'($urandom);
    p.right_y = 16'($urandom);
    p.left_shoulder = 1'($urandom_range(0, 1));
    p.right_shoulder = 1'($urandom_range(0, 1));
    p.start_button = 1'($urandom_range(0, 1));
    p.a_button = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: begin
        p.connected = 1'b1;
        p.left_x = rand_axis(ldz);
        p.left_y = rand_axis(ldz);
        if ($urandom_range(0, 5) == 0) p.left_y = $urandom_range(0, 1) ? p.left_x : -p.left_x;
      end
      1: begin
        p.connected = 1'b1;
        p.left_x = rand_inside(ldz);
        p.left_y = rand_inside(ldz);
        p.right_x = rand_axis(rdz);
        p.right_y = rand_axis(rdz);
        if ($urandom_range(0, 5) == 0) p.right_y = $urandom_range(0, 1) ? p.right_x : -p.right_x;
      end
      2: begin
        p.connected = 1'b1;
        p.left_x = rand_inside(ldz);
        p.left_y = rand_inside(ldz);
        p.right_x = rand_inside(rdz);
        p.right_y = rand_inside(rdz);
        if (!p.left_shoulder && !p.right_shoulder) p.right_shoulder = 1'b1;
      end
      3: begin
        p.connected = 1'b1;
        p.left_x = rand_inside(ldz);
        p.left_y = rand_inside(ldz);
        p.right_x = rand_inside(rdz);
        p.right_y = rand_inside(rdz);
        p.left_shoulder = 1'b0;
        p.right_shoulder = 1'b0;
        if (!p.start_button && !p.a_button) p.a_button = 1'b1;
      end
      4: begin
        p = mk(1, 0, 0, 0, 0, 0, 0, 0, 0);
        p.left_x = rand_inside(ldz);
        p.left_y = rand_inside(ldz);
        p.right_x = rand_inside(rdz);
        p.right_y = rand_inside(rdz);
      end
      5: p.connected = 1'b0;
      default: ;
    endcase
    return p;
  endfunction

  // Offer one poll and hold it until the transfer
  task automatic send_poll(in_item_t p);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= p;
    do @(posedge clk); while (in_stall);
    board.note_poll(p);
  endtask

  // Runs of held polls with random content and some noise in between
  task automatic random_stream(int unsigned count);
    in_item_t    base;
    int unsigned sent;
    int unsigned run;
    sent = 0;
    while (sent < count) begin
      base = rand_poll(int'(board.left_dz), int'(board.right_dz));
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
      for (int unsigned k = 0; k < run && sent < count; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_poll(rand_poll(int'(board.left_dz), int'(board.right_dz)));
        else send_poll(base);
        sent++;
      end
    end
  endtask

  // Drop valid and wait until every result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all four registers while the block is idle
  task automatic configure(int ldz, int rdz, int rpt, int rh);
    logic [CFG_ADDR_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{CFG_LEFT_DEAD_ZONE, CFG_RIGHT_DEAD_ZONE, CFG_REPEAT_DELAY, CFG_RUMBLE_HOLD};
    val[0] = 15'(ldz);
    val[1] = 15'(rdz);
    val[2] = {7'($urandom), 8'(rpt)};
    val[3] = {7'($urandom), 8'(rh)};
    settle();
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_addr <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      board.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed polls under the reset settings
    send_poll(mk(0, 32767, 0, 32767, 0, 1, 1, 1, 1));
    send_poll(mk(1, 0, 0, 0, 0, 0, 0, 0, 0));
    send_poll(mk(1, 32767, 0, 0, 0, 0, 0, 0, 0));
    send_poll(mk(1, -32768, 0, 0, 0, 0, 0, 0, 0));
    send_poll(mk(1, 0, 32767, 0, 0, 0, 0, 0, 0));
    send_poll(mk(1, 0, -32768, 0, 0, 0, 0, 0, 0));
    send_poll(mk(1, 10000, -10000, 0, 0, 0, 0, 0, 0));
    send_poll(mk(1, 7848, -7848, 0, 0, 0, 0, 0, 0));
    send_poll(mk(1, 7849, 0, 0, 0, 0, 0, 0, 0));
    send_poll(mk(1, 100, -7849, 0, 0, 0, 0, 0, 0));
    send_poll(mk(1, 0, 0, 32767, 0, 0, 0, 0, 0));
    send_poll(mk(1, 0, 0, -32768, 0, 0, 0, 0, 0));
    send_poll(mk(1, 0, 0, 0, 32767, 0, 0, 0, 0));
    send_poll(mk(1, 0, 0, 0, -32768, 0, 0, 0, 0));
    send_poll(mk(1, 0, 0, -9000, 9000, 0, 0, 0, 0));
    send_poll(mk(1, 0, 0, 8688, -8688, 0, 0, 0, 0));
    send_poll(mk(1, 0, 0, 0, 0, 1, 0, 0, 0));
    send_poll(mk(1, 0, 0, 0, 0, 0, 1, 0, 0));
    send_poll(mk(1, 0, 0, 0, 0, 1, 1, 1, 1));
    send_poll(mk(1, 0, 0, 0, 0, 0, 0, 1, 0));
    // Held pause: suppressed while the rumble still restarts
    repeat (3) send_poll(mk(1, 0, 0, 0, 0, 0, 0, 0, 1));
    send_poll(mk(1, 32767, 32767, 32767, 32767, 1, 1, 1, 1));
    send_poll(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    random_stream(220);

    // Settings sweep, extremes first
    idle_pct = 20;
    configure(0, 0, 0, 1);
    random_stream(220);
    idle_pct = 10;
    configure(32767, 32767, 255, 255);
    random_stream(220);
    idle_pct = 30;
    configure(1, 32767, 1, 0);
    random_stream(220);
    idle_pct = 0;
    configure(32767, 0, 3, 2);
    random_stream(220);
    idle_pct = 15;
    configure($urandom_range(0, 32767), $urandom_range(0, 32767),
              $urandom_range(0, 12), $urandom_range(1, 6));
    random_stream(220);
    idle_pct = 25;
    configure(4000, 12000, 5, 1);
    random_stream(220);

    // Last part without idling on either side
    configure($urandom_range(0, 20000), $urandom_range(0, 20000),
              $urandom_range(0, 20), $urandom_range(1, 20));
    idle_pct = 0;
    random_stream(250);

    settle();
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
